@@ rtl/core/qpht_pkg.sv @@
// Shared types and constants for the quadratic probing hash table.
// Holds field widths, operation and status codes and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

  localparam int DEFAULT_SLOTS = 16;
  localparam int KEY_W         = 31;
  localparam int PAY_W         = 31;
  localparam int SLOT_OUT_W    = 4;

  // Home slot reduction by reciprocal multiplication; the reciprocal is one bit
  // wider than the key.
  localparam int RECIP_W       = KEY_W + 1;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [PAY_W-1:0]        found_pay;
    logic                    has_link;
    logic [SLOT_OUT_W-1:0]   link_slot;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/qpht_front.sv @@
// Front end: accepts a transaction and reduces its key to the home slot.
// Depends on qpht_pkg; feeds qpht_queue.
`timescale 1ns / 1ps
`default_nettype none

module qpht_front import qpht_pkg::*; #(
  parameter int TABLE_SLOTS = DEFAULT_SLOTS,
  parameter int SLOT_W      = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_func,
  input  wire logic [KEY_W-1:0]                     in_key,
  input  wire logic [PAY_W-1:0]                     in_pay,
  input  wire logic                                 clr_busy,
  output logic                                      q_valid,
  input  wire logic                                 q_ready,
  output logic [1+KEY_W+PAY_W+SLOT_W-1:0]           q_data
);

  // Quotient = (key * RECIP) >> RECIP_SH, exact for every key below 2^KEY_W
  // because 2^SLOT_W >= TABLE_SLOTS and RECIP is the rounded-up reciprocal.
  localparam int                  RECIP_SH   = KEY_W + SLOT_W;
  localparam longint unsigned     RECIP_FULL = ((64'd1 << RECIP_SH) + 64'(TABLE_SLOTS)
                                                - 64'd1) / 64'(TABLE_SLOTS);
  localparam logic [RECIP_W-1:0]  RECIP      = RECIP_W'(RECIP_FULL);
  localparam logic [SLOT_W-1:0]   N_LOW      = SLOT_W'(TABLE_SLOTS);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_MOD  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t                  state_r, state_nxt;
  logic                     func_r;
  logic [KEY_W-1:0]         key_r;
  logic [PAY_W-1:0]         pay_r;
  logic [SLOT_W-1:0]        quo_r, quo_nxt;
  logic [SLOT_W-1:0]        rem_r, rem_nxt;
  logic [KEY_W+RECIP_W-1:0] prod;
  logic [2*SLOT_W-1:0]      qn;
  logic                     load;

  assign in_ready = (state_r == F_IDLE) && !clr_busy;
  assign load     = in_valid && in_ready;
  assign q_valid  = (state_r == F_PUSH);
  assign q_data   = {func_r, key_r, pay_r, rem_r};

  // Only the low quotient bits matter: the remainder is below 2^SLOT_W.
  assign prod = {{RECIP_W{1'b0}}, key_r} * {{KEY_W{1'b0}}, RECIP};
  assign qn   = {{SLOT_W{1'b0}}, quo_r} * {{SLOT_W{1'b0}}, N_LOW};

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      F_IDLE: begin
        if (load) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        quo_nxt   = prod[RECIP_SH +: SLOT_W];
        state_nxt = F_MOD;
      end
      F_MOD: begin
        rem_nxt   = key_r[SLOT_W-1:0] - qn[SLOT_W-1:0];
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      func_r <= in_func;
      key_r  <= in_key;
      pay_r  <= in_pay;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/qpht_queue.sv @@
// Two-entry queue between the front end and the probe engine.
// Depends on qpht_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module qpht_queue import qpht_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);

  logic [DATA_W-1:0] ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push, pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/qpht_back.sv @@
// Probe engine: walks the quadratic probe sequence over the record memories,
// inserts or searches, and holds the result register. Depends on qpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpht_back import qpht_pkg::*; #(
  parameter int TABLE_SLOTS = DEFAULT_SLOTS,
  parameter int SLOT_W      = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 q_valid,
  output logic                                      q_ready,
  input  wire logic [1+KEY_W+PAY_W+SLOT_W-1:0]      q_data,
  output logic                                      clr_busy,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output result_t                                   out_res
);

  localparam int CNT_W = SLOT_W + 1;
  localparam logic [SLOT_W:0]   N_EXT    = (SLOT_W+1)'(TABLE_SLOTS);
  localparam logic [CNT_W-1:0]  N_CNT    = CNT_W'(TABLE_SLOTS);
  localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(TABLE_SLOTS - 1);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PROBE = 5'b00100,
    S_LINK  = 5'b01000,
    S_DONE  = 5'b10000
  } bstate_t;

  typedef struct packed {
    logic             occ;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } rec_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] target;
  } lnk_t;

  rec_t rec_mem [TABLE_SLOTS];
  lnk_t lnk_mem [TABLE_SLOTS];

  bstate_t           state_r, state_nxt;
  logic              func_r, func_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [PAY_W-1:0]  pay_r, pay_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [SLOT_W-1:0] odd_r, odd_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic [CNT_W-1:0]  chk_r, chk_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0] rd_pos_r, rd_pos_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [SLOT_W-1:0] prev_r, prev_nxt;
  logic [SLOT_W-1:0] new_slot_r, new_slot_nxt;
  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;
  result_t           res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, out_res_nxt;

  rec_t              rec_q;
  lnk_t              lnk_q;
  logic              rec_we, lnk_we;
  logic [SLOT_W-1:0] rec_waddr, lnk_waddr;
  rec_t              rec_wdata;
  lnk_t              lnk_wdata;
  logic              last_probe;

  function automatic logic [SLOT_W-1:0] mod_add(input logic [SLOT_W:0] a,
                                                 input logic [SLOT_W:0] b);
    logic [SLOT_W:0] s;
    s = a + b;
    if (s >= N_EXT) begin
      s = s - N_EXT;
    end
    return s[SLOT_W-1:0];
  endfunction

  assign q_ready    = (state_r == S_IDLE);
  assign clr_busy   = (state_r == S_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_res    = out_res_r;
  assign last_probe = (chk_r == LAST_CNT);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    pos_nxt       = pos_r;
    odd_nxt       = odd_r;
    issue_nxt     = issue_r;
    chk_nxt       = chk_r;
    rd_vld_nxt    = rd_vld_r;
    rd_pos_nxt    = rd_pos_r;
    have_prev_nxt = have_prev_r;
    prev_nxt      = prev_r;
    new_slot_nxt  = new_slot_r;
    clr_idx_nxt   = clr_idx_r;
    res_nxt       = res_r;
    rec_we        = 1'b0;
    rec_waddr     = rd_pos_r;
    rec_wdata     = '{occ: 1'b1, key: key_r, pay: pay_r};
    lnk_we        = 1'b0;
    lnk_waddr     = rd_pos_r;
    lnk_wdata     = '{valid: 1'b0, target: '0};

    // Drain the result register, then allow a reload in the same cycle.
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;

    unique case (state_r)
      S_CLEAR: begin
        rec_we      = 1'b1;
        rec_waddr   = clr_idx_r;
        rec_wdata   = '{occ: 1'b0, key: '0, pay: '0};
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          {func_nxt, key_nxt, pay_nxt, pos_nxt} = q_data;
          odd_nxt       = SLOT_W'(1);
          issue_nxt     = '0;
          chk_nxt       = '0;
          rd_vld_nxt    = 1'b0;
          have_prev_nxt = 1'b0;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        // Issue side: one read per cycle, next slot by adding the next odd number.
        if (issue_r != N_CNT) begin
          rd_vld_nxt = 1'b1;
          rd_pos_nxt = pos_r;
          pos_nxt    = mod_add({1'b0, pos_r}, {1'b0, odd_r});
          odd_nxt    = mod_add({1'b0, odd_r}, (SLOT_W+1)'(2));
          issue_nxt  = issue_r + 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
        // Check side: examine the slot read in the previous cycle.
        if (rd_vld_r) begin
          chk_nxt = chk_r + 1'b1;
          if (func_r == FUNC_INSERT) begin
            if (!rec_q.occ) begin
              rec_we       = 1'b1;
              lnk_we       = 1'b1;
              new_slot_nxt = rd_pos_r;
              res_nxt      = '{status: ST_INSERTED, slot: SLOT_OUT_W'(rd_pos_r),
                               found_pay: '0, has_link: 1'b0, link_slot: '0};
              state_nxt    = have_prev_r ? S_LINK : S_DONE;
            end else begin
              prev_nxt      = rd_pos_r;
              have_prev_nxt = 1'b1;
              if (last_probe) begin
                res_nxt   = '{status: ST_FULL, slot: '0, found_pay: '0,
                              has_link: 1'b0, link_slot: '0};
                state_nxt = S_DONE;
              end
            end
          end else begin
            if (!rec_q.occ) begin
              res_nxt   = '{status: ST_NOT_FOUND, slot: '0, found_pay: '0,
                            has_link: 1'b0, link_slot: '0};
              state_nxt = S_DONE;
            end else if (rec_q.key == key_r) begin
              res_nxt   = '{status: ST_FOUND, slot: SLOT_OUT_W'(rd_pos_r),
                            found_pay: rec_q.pay, has_link: lnk_q.valid,
                            link_slot: lnk_q.valid ? SLOT_OUT_W'(lnk_q.target) : '0};
              state_nxt = S_DONE;
            end else if (last_probe) begin
              res_nxt   = '{status: ST_NOT_FOUND, slot: '0, found_pay: '0,
                            has_link: 1'b0, link_slot: '0};
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_LINK: begin
        // Chain the last occupied probed slot to the new record.
        lnk_we    = 1'b1;
        lnk_waddr = prev_r;
        lnk_wdata = '{valid: 1'b1, target: new_slot_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    key_r       <= key_nxt;
    pay_r       <= pay_nxt;
    pos_r       <= pos_nxt;
    odd_r       <= odd_nxt;
    issue_r     <= issue_nxt;
    chk_r       <= chk_nxt;
    rd_pos_r    <= rd_pos_nxt;
    have_prev_r <= have_prev_nxt;
    prev_r      <= prev_nxt;
    new_slot_r  <= new_slot_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

  // Record and link memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_q <= rec_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    lnk_q <= lnk_mem[pos_r];
  end

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result presented during clearing pass");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (issue_r <= N_CNT))
    else $error("probe issue count beyond slot count");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_we || lnk_we) |-> (state_r == S_CLEAR || state_r == S_PROBE ||
                            state_r == S_LINK))
    else $error("memory write outside clear, probe or link");

  a_link_after_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |-> ($past(state_r) == S_PROBE && func_r == FUNC_INSERT &&
                             have_prev_r))
    else $error("link write without preceding insert");

endmodule

`default_nettype wire

@@ rtl/core/quadratic_probe_hash_table.sv @@
// Flow: the front end registers an accepted transaction, reduces its key to the
//   home slot and pushes it into the queue; the probe engine pops it when idle,
//   takes k probes, k from 1 to TABLE_SLOTS, writes a link for an insert that
//   chains, and loads the result register; it pops the next one only after that.
//   The front end takes no new transaction until its item is pushed, and
//   overlaps with probing of earlier work.
// Reset: synchronous, active low; a clearing pass then marks all slots free,
//   and no transaction is accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_probe_hash_table import qpht_pkg::*; #(
  parameter int TABLE_SLOTS = DEFAULT_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // key [30:0], pay [61:31], zero fill [63:62]
  input  wire logic        in_tuser,   // func [0]: insert or search
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // slot [3:0], found_pay [34:4], has_link [35],
                                       // link_slot [39:36]
  output logic [1:0]       out_tuser   // status [1:0]
);

  // Slot index width follows the slot count; a count of one still needs one bit.
  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int ITEM_W = 1 + KEY_W + PAY_W + SLOT_W;

  logic              fq_valid, fq_ready;
  logic [ITEM_W-1:0] fq_data;
  logic              qb_valid, qb_ready;
  logic [ITEM_W-1:0] qb_data;
  logic              clr_busy;
  result_t           res;

  // Front end: take one transaction, reduce the key to its home slot.
  qpht_front #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_key   (in_tdata[KEY_W-1:0]),
    .in_pay   (in_tdata[KEY_W+PAY_W-1:KEY_W]),
    .clr_busy (clr_busy),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  // Short queue so the front keeps taking work while the probe engine runs.
  qpht_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // Probe engine with the record memories and the result register.
  qpht_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .clr_busy  (clr_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {res.link_slot, res.has_link, res.found_pay, res.slot};
  assign out_tuser = res.status;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for quadratic_probe_hash_table: directed and random
// insert/search traffic checked against an in-bench model of the table.
// Depends on qpht_pkg and the quadratic_probe_hash_table RTL.
`timescale 1ns / 1ps

module tb;
  import qpht_pkg::*;

  localparam int SLOTS       = DEFAULT_SLOTS;
  localparam int NUM_RANDOM  = 1935;
  localparam int CALM_TAIL   = 200;      // transactions at the end with no idling
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off to back up the block
  localparam int HOLD_AFTER  = 150;      // results seen before the hold-off starts
  localparam int DRAIN       = 40;       // cycles to wait after the last result
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic             func;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } table_op_t;

  // Clock, reset and DUT ports; every input starts at a known value.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [63:0] in_tdata   = '0;    // key [30:0], pay [61:31], zero fill [63:62]
  logic        in_tuser   = 1'b0;  // func [0]
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [39:0] out_tdata;          // slot [3:0], found_pay [34:4], has_link [35],
                                   // link_slot [39:36]
  logic [1:0]  out_tuser;          // status [1:0]

  quadratic_probe_hash_table #(.TABLE_SLOTS(SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the table contents, updated as each transaction is accepted.
  bit               occ      [SLOTS];
  bit [KEY_W-1:0]   tbl_key  [SLOTS];
  bit [PAY_W-1:0]   tbl_pay  [SLOTS];
  bit               lnk_ok   [SLOTS];
  int               lnk_to   [SLOTS];

  table_op_t ops_to_send[$];
  result_t   expected_replies[$];

  int total_ops;
  int sent_cnt  = 0;   // accepted input transactions (nonblocking updates)
  int got_cnt   = 0;   // accepted result transactions (nonblocking updates)
  int errors    = 0;
  int n_stored  = 0;
  int n_full    = 0;
  int n_hit     = 0;
  int n_miss    = 0;

  // Walk the quadratic probe sequence exactly as the hardware should, apply
  // the side effects of an insert, and return the reply it must produce.
  function automatic result_t predict_table_op(table_op_t op);
    result_t r;
    int      home;
    int      s;
    int      prev;
    bit      have_prev;
    r         = '0;
    home      = int'(op.key % SLOTS);
    prev      = 0;
    have_prev = 1'b0;
    if (op.func == FUNC_INSERT) begin
      r.status = ST_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        s = (home + i * i) % SLOTS;
        if (!occ[s]) begin
          occ[s]     = 1'b1;
          tbl_key[s] = op.key;
          tbl_pay[s] = op.pay;
          lnk_ok[s]  = 1'b0;
          lnk_to[s]  = 0;
          // chain the last occupied slot we stepped over to the new record
          if (have_prev) begin
            lnk_ok[prev] = 1'b1;
            lnk_to[prev] = s;
          end
          r.status = ST_INSERTED;
          r.slot   = s[SLOT_OUT_W-1:0];
          break;
        end
        prev      = s;
        have_prev = 1'b1;
      end
      if (r.status == ST_FULL) n_full++;
      else n_stored++;
    end else begin
      r.status = ST_NOT_FOUND;
      for (int i = 0; i < SLOTS; i++) begin
        s = (home + i * i) % SLOTS;
        if (!occ[s]) break;
        if (tbl_key[s] == op.key) begin
          r.status    = ST_FOUND;
          r.slot      = s[SLOT_OUT_W-1:0];
          r.found_pay = tbl_pay[s];
          if (lnk_ok[s]) begin
            r.has_link  = 1'b1;
            r.link_slot = lnk_to[s][SLOT_OUT_W-1:0];
          end
          break;
        end
      end
      if (r.status == ST_FOUND) n_hit++;
      else n_miss++;
    end
    return r;
  endfunction

  function automatic bit idling_ok(int done_cnt);
    // quiet windows give stretches with no idling; the tail runs flat out
    return (done_cnt < total_ops - CALM_TAIL) && (((done_cnt / 128) % 4) != 3);
  endfunction

  // Driver: offer queued operations, predict each one as it is accepted, and
  // insert random bursts of idle cycles between transactions.
  table_op_t cur_op;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_replies.push_back(predict_table_op(cur_op));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (ops_to_send.size() > 0) begin
          cur_op = ops_to_send.pop_front();
          in_tdata  <= {2'b00, cur_op.pay, cur_op.key};
          in_tuser  <= cur_op.func;
          in_tvalid <= 1'b1;
          // schedule an idle burst after this transaction goes through
          if (idling_ok(sent_cnt) && $urandom_range(0, 4) == 0)
            gap_left = $urandom_range(1, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stall bursts plus one long hold-off so the block
  // backs up and drops in_tready while the driver keeps offering.
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  held_once  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!held_once && got_cnt >= HOLD_AFTER) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idling_ok(got_cnt) && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got_cnt <= got_cnt + 1;
      if (expected_replies.size() == 0) begin
        $error("unexpected result transaction: status %0d slot %0d", out_tuser,
               out_tdata[3:0]);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (out_tuser != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          errors++;
        end
        if (out_tdata[3:0] != want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_tdata[3:0]);
          errors++;
        end
        if (out_tdata[34:4] != want.found_pay) begin
          $error("found_pay: expected %0h, got %0h", want.found_pay, out_tdata[34:4]);
          errors++;
        end
        if (out_tdata[35] != want.has_link) begin
          $error("has_link: expected %0d, got %0d", want.has_link, out_tdata[35]);
          errors++;
        end
        if (out_tdata[39:36] != want.link_slot) begin
          $error("link_slot: expected %0d, got %0d", want.link_slot, out_tdata[39:36]);
          errors++;
        end
      end
    end
  end

  // Watchdog: covers the reset clearing pass, the hold-off and worst-case probing.
  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_op(logic func, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
    table_op_t op;
    op.func = func;
    op.key  = key;
    op.pay  = pay;
    ops_to_send.push_back(op);
  endtask

  initial begin
    logic [KEY_W-1:0] known_keys[$];
    logic [KEY_W-1:0] k;
    logic [PAY_W-1:0] p;
    logic [31:0]      rnd;

    // Directed: empty-table miss, collisions on one home slot building a
    // chain, full probe group, miss after every probe, duplicates, extremes.
    queue_op(FUNC_SEARCH, 31'd0,          31'h7FFF_FFFF);  // miss on empty table
    queue_op(FUNC_INSERT, 31'd0,          31'h7FFF_FFFF);
    queue_op(FUNC_INSERT, 31'd16,         31'd0);          // same home, gets linked
    queue_op(FUNC_INSERT, 31'h7FFF_FFFF,  31'h5555_5555);
    queue_op(FUNC_INSERT, 31'd32,         31'h2AAA_AAAA);
    queue_op(FUNC_INSERT, 31'd48,         31'd1);
    queue_op(FUNC_INSERT, 31'd64,         31'd7);          // probe group full
    queue_op(FUNC_SEARCH, 31'd0,          31'd0);          // hit with a link
    queue_op(FUNC_SEARCH, 31'd48,         31'h7FFF_FFFF);  // hit, end of chain
    queue_op(FUNC_SEARCH, 31'd64,         31'd3);          // miss after all probes
    queue_op(FUNC_SEARCH, 31'd81,         31'h1234_5678);  // miss at a free slot
    queue_op(FUNC_INSERT, 31'h7FFF_FFFF,  31'd2);          // duplicate key
    queue_op(FUNC_SEARCH, 31'h7FFF_FFFF,  31'd0);          // first copy wins
    queue_op(FUNC_INSERT, 31'h4000_0006,  31'h4000_0000);
    queue_op(FUNC_SEARCH, 31'h4000_0006,  31'h7FFF_FFFF);
    queue_op(FUNC_SEARCH, 31'h3FFF_FFF6,  31'd0);          // home match, key differs
    queue_op(FUNC_SEARCH, 31'd16,         31'd5);
    known_keys = '{31'd0, 31'd16, 31'h7FFF_FFFF, 31'd32, 31'd48, 31'h4000_0006};

    // Random: mostly searches, about two thirds of them for previously inserted keys;
    // the rest inserts, half clustered on four home slots and half fully random keys.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      rnd = $urandom;
      k   = rnd[KEY_W-1:0];
      rnd = $urandom;
      p   = rnd[PAY_W-1:0];
      if ($urandom_range(0, 99) < 40) begin
        if ($urandom_range(0, 1) == 0) k[3:0] = 4'($urandom_range(0, 3) * 4);
        queue_op(FUNC_INSERT, k, p);
        known_keys.push_back(k);
      end else begin
        if ($urandom_range(0, 99) < 65)
          k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        queue_op(FUNC_SEARCH, k, p);
      end
    end
    total_ops = ops_to_send.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every operation to be accepted and answered, then drain.
    do @(negedge clk);
    while (ops_to_send.size() != 0 || in_tvalid || expected_replies.size() != 0);
    repeat (DRAIN) @(negedge clk);

    if (expected_replies.size() != 0 || got_cnt != total_ops) begin
      $error("%0d predicted results never arrived", expected_replies.size());
      errors++;
    end
    $display("Ran %0d table operations: %0d stored, %0d rejected as full,",
             total_ops, n_stored, n_full);
    $display("  %0d searches hit and %0d missed, with idle bursts and a long hold-off.",
             n_hit, n_miss);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/qpht_pkg.sv
rtl/core/qpht_front.sv
rtl/core/qpht_queue.sv
rtl/core/qpht_back.sv
rtl/core/quadratic_probe_hash_table.sv
verif/tb.sv
